// ===== hw/rtl/sorted_node_insert_rekey_defines.svh =====
// assertion macros for the sorted node block
`ifndef SORTED_NODE_INSERT_REKEY_DEFINES_SVH
`define SORTED_NODE_INSERT_REKEY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, reset masked
`define SNIR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snir assertion failed");

// next-cycle implication, reset masked
`define SNIR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snir assertion failed");

`else

`define SNIR_ASSERT_NOW(name, ante, cons)
`define SNIR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/snir_pkg.sv =====
package snir_pkg;

    // node geometry
    localparam int ORDER        = 16;
    localparam int KEY_BITS     = 32;
    localparam int VALUE_BITS   = 32;
    localparam int OUT_KEY_BITS = 32;
    localparam int ADDR_BITS    = $clog2(ORDER);
    localparam int CNT_BITS     = $clog2(ORDER + 1);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REKEY  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_SUCCESS   = 2'd0,
        STATUS_EXISTS    = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // request beat
    typedef struct packed {
        logic                  operation;
        logic [KEY_BITS-1:0]   key;
        logic [KEY_BITS-1:0]   new_key;
        logic [VALUE_BITS-1:0] entry_value;
    } request_t;

    // result beat
    typedef struct packed {
        status_t                 status;
        logic [OUT_KEY_BITS-1:0] largest_key;
        logic                    node_empty;
    } result_t;

endpackage

// ===== hw/rtl/snir_ram.sv =====
module snir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sorted_node_insert_rekey.sv =====
// One sorted tree node of ORDER key/value slots kept in two single-port-read
// memories. start is taken when busy is low; the result beat appears on
// result for exactly one cycle with done high and cannot be held off, so the
// receiver must capture it then. The key memory is walked one slot a cycle
// through its single read port. An insert that lands inside the occupied
// slots first shifts the larger entries one slot right and then places the
// new pair; one that goes on the end of the node has no entries to move.
// A rekey or an insert stops the walk on a matching key; a rekey that misses
// and an insert into a full node report after the walk of every slot held.
// busy stays high until the cycle in which done is raised, so a new request
// may be taken in that same cycle.
`include "sorted_node_insert_rekey_defines.svh"

module sorted_node_insert_rekey (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  snir_pkg::request_t request,
    output logic               done,
    output snir_pkg::result_t  result
);

    import snir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_REPORT
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [KEY_BITS-1:0]   largest_reg, largest_next;
    logic                  op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   new_key_reg, new_key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_BITS-1:0]  cidx_reg, cidx_next;
    logic [CNT_BITS-1:0]   pos_reg, pos_next;
    logic [ADDR_BITS-1:0]  wdst_reg, wdst_next;
    status_t               status_reg, status_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    // memory ports
    logic                  key_we, val_we;
    logic [ADDR_BITS-1:0]  key_waddr, val_waddr, rd_addr;
    logic [KEY_BITS-1:0]   key_wdata, key_rdata;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;

    // helpers
    logic [CNT_BITS-1:0]   idx_dec, count_dec, count_inc;
    logic                  issue;

    assign idx_dec   = idx_reg - CNT_BITS'(1);
    assign count_dec = count_reg - CNT_BITS'(1);
    assign count_inc = count_reg + CNT_BITS'(1);
    assign issue     = (idx_reg < count_reg);

    snir_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ORDER)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    snir_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ORDER)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        new_key_next = new_key_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        cidx_next    = cidx_reg;
        pos_next     = pos_reg;
        wdst_next    = wdst_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        key_we    = 1'b0;
        val_we    = 1'b0;
        key_waddr = wdst_reg;
        val_waddr = wdst_reg;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        rd_addr   = idx_reg[ADDR_BITS-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = request.operation;
                    key_next     = request.key;
                    new_key_next = request.new_key;
                    value_next   = request.entry_value;
                    idx_next     = '0;
                    pos_next     = '0;
                    pend_next    = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            // walk the occupied slots, compare one key a cycle
            ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next  = idx_reg + CNT_BITS'(1);
                    cidx_next = idx_reg[ADDR_BITS-1:0];
                end
                if (pend_reg)
                begin
                    if (key_rdata == key_reg)
                    begin
                        if (op_reg == OP_REKEY)
                        begin
                            key_we      = 1'b1;
                            key_waddr   = cidx_reg;
                            key_wdata   = new_key_reg;
                            status_next = STATUS_SUCCESS;
                            if (cidx_reg == count_dec[ADDR_BITS-1:0])
                            begin
                                largest_next = new_key_reg;
                            end
                        end
                        else
                        begin
                            status_next = STATUS_EXISTS;
                        end
                        pend_next  = 1'b0;
                        state_next = ST_REPORT;
                    end
                    else if (key_rdata < key_reg)
                    begin
                        pos_next = pos_reg + CNT_BITS'(1);
                    end
                end
                else if (!issue)
                begin
                    if (op_reg == OP_REKEY)
                    begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = ST_REPORT;
                    end
                    else if (count_reg == CNT_BITS'(ORDER))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = ST_REPORT;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = ST_SHIFT;
                    end
                end
            end

            // move larger entries one slot right, highest first
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                end
                if (idx_reg > pos_reg)
                begin
                    rd_addr   = idx_dec[ADDR_BITS-1:0];
                    wdst_next = idx_reg[ADDR_BITS-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end

            // drop the new pair into its slot
            ST_PLACE:
            begin
                key_we      = 1'b1;
                val_we      = 1'b1;
                key_waddr   = pos_reg[ADDR_BITS-1:0];
                val_waddr   = pos_reg[ADDR_BITS-1:0];
                key_wdata   = key_reg;
                val_wdata   = value_reg;
                count_next  = count_inc;
                status_next = STATUS_SUCCESS;
                if (pos_reg == count_reg)
                begin
                    largest_next = key_reg;
                end
                state_next = ST_REPORT;
            end

            ST_REPORT:
            begin
                done_next          = 1'b1;
                result_next.status = status_reg;
                if (count_reg == '0)
                begin
                    result_next.largest_key = '0;
                    result_next.node_empty  = 1'b1;
                end
                else
                begin
                    result_next.largest_key = OUT_KEY_BITS'(largest_reg);
                    result_next.node_empty  = 1'b0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            largest_reg <= '0;
            op_reg      <= OP_INSERT;
            key_reg     <= '0;
            new_key_reg <= '0;
            value_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            cidx_reg    <= '0;
            pos_reg     <= '0;
            wdst_reg    <= '0;
            status_reg  <= STATUS_SUCCESS;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            largest_reg <= largest_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            new_key_reg <= new_key_next;
            value_reg   <= value_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            cidx_reg    <= cidx_next;
            pos_reg     <= pos_next;
            wdst_reg    <= wdst_next;
            status_reg  <= status_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `SNIR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(ORDER))
    `SNIR_ASSERT_NEXT(a_report_done, state_reg == ST_REPORT, done_reg)
    `SNIR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SNIR_ASSERT_NEXT(a_place_count, state_reg == ST_PLACE, count_reg == $past(count_inc))
    `SNIR_ASSERT_NOW(a_empty_flag, done_reg, result_reg.node_empty == (count_reg == '0))

endmodule
